FILE: rtl/alm_pkg.sv
`timescale 1ns / 1ps

package alm_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned LINK_W    = 7;
	localparam int unsigned NODES_DEF = 64;

	localparam logic [LINK_W-1:0] NIL = '1;

	typedef enum logic [1:0] {
		REQ_FRONT = 2'd0,
		REQ_END   = 2'd1,
		REQ_TRAV  = 2'd2,
		REQ_NONE  = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		STS_DONE  = 2'd0,
		STS_FULL  = 2'd1,
		STS_ELEM  = 2'd2,
		STS_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAKE,
		ST_WALK,
		ST_TRAV,
		ST_RESP
	} state_t;

	// Read address source for the link and value memories
	typedef enum logic [1:0] {
		RD_FREE,
		RD_HEAD,
		RD_LINK
	} rd_src_t;

	// Link write data source
	typedef enum logic [1:0] {
		WD_HEAD,
		WD_NIL,
		WD_NODE
	} wr_src_t;

	typedef struct packed {
		rd_src_t rd_sel;
		logic    link_rd;
		logic    value_rd;
		logic    link_wr;
		logic    wr_at_cur;
		wr_src_t wr_src;
		logic    value_wr;
		logic    take;
		logic    head_to_node;
		logic    capture;
		logic    cur_ld;
		logic    out_ld;
		logic    out_elem;
		status_t out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic free_ok;
		logic head_ok;
		logic link_ok;
		logic out_free;
	} dp_sts_t;

	// Link value after reset: each node points at the next, the last one is null
	function automatic logic [LINK_W-1:0] link_reset(input logic [LINK_W-1:0] idx,
		input int unsigned nodes);
		logic [LINK_W:0] nxt;
		nxt = {1'b0, idx} + 1'b1;
		return (32'(nxt) < nodes) ? nxt[LINK_W-1:0] : NIL;
	endfunction

endpackage

FILE: rtl/alm_ctrl.sv
`timescale 1ns / 1ps

module alm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_type,
	output logic             req_stall,
	input  alm_pkg::dp_sts_t sts,
	output alm_pkg::dp_cmd_t cmd
);
	import alm_pkg::*;

	state_t  state_q, state_d;
	logic    end_q, end_d;
	status_t code_q, code_d;
	req_e_t  rtype;

	assign rtype     = req_e_t'(req_type);
	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
			code_q  <= STS_DONE;
		end else begin
			state_q <= state_d;
			end_q   <= end_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d = state_q;
		end_d   = end_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.rd_sel     = RD_FREE;
		cmd.wr_src     = WD_HEAD;
		cmd.out_status = STS_DONE;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (rtype) inside
						REQ_FRONT, REQ_END: begin
							if (sts.free_ok) begin
								cmd.capture = 1'b1;
								cmd.rd_sel  = RD_FREE;
								cmd.link_rd = 1'b1;
								end_d       = (rtype == REQ_END);
								state_d     = ST_TAKE;
							end else begin
								code_d  = STS_FULL;
								state_d = ST_RESP;
							end
						end
						REQ_TRAV: begin
							if (sts.head_ok) begin
								cmd.rd_sel   = RD_HEAD;
								cmd.link_rd  = 1'b1;
								cmd.value_rd = 1'b1;
								state_d      = ST_TRAV;
							end else begin
								code_d  = STS_EMPTY;
								state_d = ST_RESP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_TAKE: begin
				// Unlink the node from the free list and store the value
				cmd.take     = 1'b1;
				cmd.value_wr = 1'b1;
				cmd.link_wr  = 1'b1;
				code_d       = STS_DONE;
				if (!end_q) begin
					cmd.wr_src       = WD_HEAD;
					cmd.head_to_node = 1'b1;
					state_d          = ST_RESP;
				end else begin
					cmd.wr_src = WD_NIL;
					if (!sts.head_ok) begin
						cmd.head_to_node = 1'b1;
						state_d          = ST_RESP;
					end else begin
						cmd.rd_sel  = RD_HEAD;
						cmd.link_rd = 1'b1;
						cmd.cur_ld  = 1'b1;
						state_d     = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (sts.link_ok) begin
					cmd.rd_sel  = RD_LINK;
					cmd.link_rd = 1'b1;
					cmd.cur_ld  = 1'b1;
				end else begin
					// Tail found: hook the new node behind it
					cmd.link_wr   = 1'b1;
					cmd.wr_at_cur = 1'b1;
					cmd.wr_src    = WD_NODE;
					state_d       = ST_RESP;
				end
			end
			ST_TRAV: begin
				if (sts.out_free) begin
					cmd.out_ld     = 1'b1;
					cmd.out_elem   = 1'b1;
					cmd.out_status = STS_ELEM;
					if (sts.link_ok) begin
						cmd.rd_sel   = RD_LINK;
						cmd.link_rd  = 1'b1;
						cmd.value_rd = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_ld     = 1'b1;
					cmd.out_status = code_q;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> sts.out_free)
		else $error("result loaded while output register busy");

	a_trav_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRAV) |-> sts.head_ok)
		else $error("traverse running on an empty list");

endmodule

FILE: rtl/alm_datapath.sv
`timescale 1ns / 1ps

module alm_datapath #(
	parameter int unsigned NODES = alm_pkg::NODES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [alm_pkg::VALUE_W-1:0] value_in,
	input  alm_pkg::dp_cmd_t                   cmd,
	output alm_pkg::dp_sts_t                   sts,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic signed [alm_pkg::VALUE_W-1:0] value_out,
	output logic [1:0]                         status,
	output logic                               last
);
	import alm_pkg::*;

	localparam int unsigned AW = $clog2(NODES);
	localparam logic [LINK_W-1:0] NODES_L = LINK_W'(NODES);

	logic signed [VALUE_W-1:0] value_mem [NODES];
	logic [LINK_W-1:0]         link_mem  [NODES];
	logic [NODES-1:0]          link_set_q;

	logic [LINK_W-1:0]         free_head_q, head_q, rlink_q;
	logic signed [VALUE_W-1:0] rval_q, val_q;
	logic [AW-1:0]             n_q, cur_q;

	logic                      out_valid_q, last_q;
	logic signed [VALUE_W-1:0] value_out_q;
	status_t                   status_q;

	logic [LINK_W-1:0] rd_full, wr_data;
	logic [AW-1:0]     rd_addr, wr_addr;

	always_comb begin
		case (cmd.rd_sel)
			RD_FREE: rd_full = free_head_q;
			RD_HEAD: rd_full = head_q;
			default: rd_full = rlink_q;
		endcase
		case (cmd.wr_src)
			WD_HEAD: wr_data = head_q;
			WD_NIL:  wr_data = NIL;
			default: wr_data = LINK_W'(n_q);
		endcase
	end

	assign rd_addr = rd_full[AW-1:0];
	assign wr_addr = cmd.wr_at_cur ? cur_q : n_q;

	assign sts.free_ok  = (free_head_q < NODES_L);
	assign sts.head_ok  = (head_q < NODES_L);
	assign sts.link_ok  = (rlink_q < NODES_L);
	assign sts.out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.value_wr) begin
			value_mem[n_q] <= val_q;
		end
		if (cmd.value_rd) begin
			rval_q <= value_mem[rd_addr];
		end
	end

	// Entries never written read as their reset link
	always_ff @(posedge clk) begin
		if (cmd.link_wr) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (cmd.link_rd) begin
			rlink_q <= link_set_q[rd_addr] ? link_mem[rd_addr]
				: link_reset(LINK_W'(rd_addr), NODES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_set_q  <= '0;
			free_head_q <= '0;
			head_q      <= NIL;
		end else begin
			if (cmd.link_wr) begin
				link_set_q[wr_addr] <= 1'b1;
			end
			if (cmd.take) begin
				free_head_q <= rlink_q;
			end
			if (cmd.head_to_node) begin
				head_q <= LINK_W'(n_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			n_q   <= free_head_q[AW-1:0];
			val_q <= value_in;
		end
		if (cmd.cur_ld) begin
			cur_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			value_out_q <= cmd.out_elem ? rval_q : '0;
			status_q    <= cmd.out_status;
			last_q      <= cmd.out_elem ? !sts.link_ok : 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign last      = last_q;

	a_head_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) || (head_q < NODES_L))
		else $error("list head neither null nor a node");

	a_free_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q == NIL) || (free_head_q < NODES_L))
		else $error("free head neither null nor a node");

	a_take_unlinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (free_head_q != LINK_W'(n_q)))
		else $error("taken node still heads the free list");

endmodule

FILE: rtl/array_linked_list_manager.sv
// Singly linked list kept in a store of NODES nodes, with a free list that chains
// every node in order after reset. req_type 0 pushes value_in at the front,
// 1 appends it at the end (one link read per node walked), 2 emits the list in order,
// one element per cycle while the output is not stalled, with last on the final one;
// an empty list gives one result with status empty. Insert into a full store is
// refused with status full and changes nothing. Request type 3 is dropped without
// a result. The rate is set by the single registered read port of the link memory.
// Only one request is in flight; a finished result waits in the output register
// while the next request is taken.
`timescale 1ns / 1ps

module array_linked_list_manager #(
	parameter int unsigned NODES = alm_pkg::NODES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [1:0]                         req_type,
	input  logic signed [alm_pkg::VALUE_W-1:0] value_in,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic signed [alm_pkg::VALUE_W-1:0] value_out,
	output logic [1:0]                         status,
	output logic                               last
);
	import alm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	alm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	alm_datapath #(
		.NODES (NODES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_in  (value_in),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value_out (value_out),
		.status    (status),
		.last      (last)
	);

endmodule
